### src/ltrr_pkg.sv
// Shared types and constants for the lock table with revoke and retry messages.
// No dependencies; every other file of the block imports this package.
package ltrr_pkg;

	localparam int NUM_LOCKS   = 64;
	localparam int NUM_CLIENTS = 16;

	// Field widths of the request and message channels
	localparam int CLIENT_W = 4;
	localparam int LOCK_W   = 6;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;

	// Index widths into the per-lock table and the waiter bitmap
	localparam int LOCK_AW = $clog2(NUM_LOCKS);
	localparam int CLI_AW  = $clog2(NUM_CLIENTS);

	localparam logic ACT_ACQUIRE = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_REPLY  = 2'd0,
		KIND_REVOKE = 2'd1,
		KIND_RETRY  = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_RETRY  = 2'd1,
		ST_RPCERR = 2'd2,
		ST_NOENT  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_REPLY,
		S_REVOKE,
		S_RETRY
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic idle;
		logic reply;
		logic revoke;
		logic retry;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic accepted;
		logic out_free;
		logic need_revoke;
		logic has_retry;
		logic retry_more;
	} sts_t;

	// One row of the lock table held in memory
	typedef struct packed {
		logic                   revoked;
		logic [CLIENT_W-1:0]    owner;
		logic [NUM_CLIENTS-1:0] waiters;
	} entry_t;

endpackage

### src/ltrr_if.sv
// Handshake channels of the lock table: configuration, request and message.
// Depends on ltrr_pkg for the field widths.
interface ltrr_cfg_if;
	import ltrr_pkg::*;
	logic valid;
	logic ready;
	logic is_primary;
	modport source (output valid, output is_primary, input ready);
	modport sink (input valid, input is_primary, output ready);
endinterface

interface ltrr_req_if;
	import ltrr_pkg::*;
	logic                valid;
	logic                ready;
	logic                action;
	logic [CLIENT_W-1:0] client_id;
	logic [LOCK_W-1:0]   lock_id;
	modport source (output valid, output action, output client_id, output lock_id, input ready);
	modport sink (input valid, input action, input client_id, input lock_id, output ready);
endinterface

interface ltrr_rsp_if;
	import ltrr_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   msg_kind;
	logic [STATUS_W-1:0] status;
	logic [CLIENT_W-1:0] target_client;
	logic [LOCK_W-1:0]   msg_lock;
	logic                last;
	modport source (output valid, output msg_kind, output status, output target_client,
		output msg_lock, output last, input ready);
	modport sink (input valid, input msg_kind, input status, input target_client,
		input msg_lock, input last, output ready);
endinterface

### src/ltrr_ctrl.sv
// Sequencing controller of the lock table: reply, then revoke or retry messages.
// Depends on ltrr_pkg for the state, command and status types.
module ltrr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  ltrr_pkg::sts_t sts,
	output ltrr_pkg::cmd_t cmd
);
	import ltrr_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (sts.accepted) state_d = S_REPLY;
			end
			S_REPLY: begin
				if (sts.out_free) begin
					if (sts.need_revoke) state_d = S_REVOKE;
					else if (sts.has_retry) state_d = S_RETRY;
					else state_d = S_IDLE;
				end
			end
			S_REVOKE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			S_RETRY: begin
				// stay until the last waiter has been sent
				if (sts.out_free && !sts.retry_more) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.idle   = (state_q == S_IDLE);
		cmd.reply  = (state_q == S_REPLY) && sts.out_free;
		cmd.revoke = (state_q == S_REVOKE) && sts.out_free;
		cmd.retry  = (state_q == S_RETRY) && sts.out_free;
	end

endmodule

### src/ltrr_datapath.sv
// Datapath of the lock table: request capture, per-lock table, waiter scan
// and the message output register. Depends on ltrr_pkg and the channel interfaces.
module ltrr_datapath (
	input  logic           clk,
	input  logic           arst_n,
	ltrr_cfg_if.sink       cfg,
	ltrr_req_if.sink       req,
	ltrr_rsp_if.source     rsp,
	input  ltrr_pkg::cmd_t cmd,
	output ltrr_pkg::sts_t sts
);
	import ltrr_pkg::*;

	logic                   primary_q;
	logic                   act_q;
	logic [CLIENT_W-1:0]    cli_q;
	logic [LOCK_W-1:0]      lk_q;
	entry_t                 entry_q;
	entry_t                 mem_q [NUM_LOCKS];
	logic [NUM_LOCKS-1:0]   held_q;
	logic [NUM_CLIENTS-1:0] scan_q;

	logic                   out_valid_q;
	kind_t                  out_kind_q;
	status_t                out_status_q;
	logic [CLIENT_W-1:0]    out_target_q;
	logic [LOCK_W-1:0]      out_lock_q;
	logic                   out_last_q;

	logic                   capture;
	logic                   out_free;
	logic                   in_range;
	logic [LOCK_AW-1:0]     lk_idx;
	logic                   held;
	logic                   grant;
	logic                   queue;
	logic                   free_ok;
	logic                   need_revoke;
	logic                   has_retry;
	status_t                reply_status;
	logic [CLI_AW-1:0]      pick;
	logic [NUM_CLIENTS-1:0] scan_rest;
	logic [NUM_CLIENTS-1:0] cli_bit;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primary_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			primary_q <= cfg.is_primary;
		end
	end

	assign req.ready = cmd.idle;
	assign capture   = req.valid && cmd.idle;

	// Capture the request and read its table row in the same edge
	always_ff @(posedge clk) begin
		if (capture) begin
			act_q   <= req.action;
			cli_q   <= req.client_id;
			lk_q    <= req.lock_id;
			entry_q <= mem_q[req.lock_id[LOCK_AW-1:0]];
		end
	end

	assign in_range = (32'(cli_q) < NUM_CLIENTS) && (32'(lk_q) < NUM_LOCKS);
	assign lk_idx   = lk_q[LOCK_AW-1:0];
	assign held     = held_q[lk_idx];
	assign cli_bit  = NUM_CLIENTS'(1) << cli_q[CLI_AW-1:0];

	assign grant   = primary_q && in_range && (act_q == ACT_ACQUIRE) && !held;
	assign queue   = primary_q && in_range && (act_q == ACT_ACQUIRE) && held;
	assign free_ok = primary_q && in_range && (act_q == ACT_RELEASE) && held
		&& (entry_q.owner == cli_q);

	assign need_revoke = queue && !entry_q.revoked;
	assign has_retry   = free_ok && (|entry_q.waiters);

	always_comb begin
		if (!primary_q) reply_status = ST_RPCERR;
		else if (grant || free_ok) reply_status = ST_OK;
		else if (queue) reply_status = ST_RETRY;
		else reply_status = ST_NOENT;
	end

	// Row update on the reply step; a grant wipes waiters and the revoke mark
	always_ff @(posedge clk) begin
		if (cmd.reply && grant) begin
			mem_q[lk_idx] <= '{revoked: 1'b0, owner: cli_q, waiters: '0};
		end else if (cmd.reply && queue) begin
			mem_q[lk_idx] <= '{revoked: 1'b1, owner: entry_q.owner,
				waiters: entry_q.waiters | cli_bit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd.reply && grant) begin
			held_q[lk_idx] <= 1'b1;
		end else if (cmd.reply && free_ok) begin
			held_q[lk_idx] <= 1'b0;
		end
	end

	// Lowest pending waiter first
	always_comb begin
		pick = '0;
		for (int i = NUM_CLIENTS - 1; i >= 0; i--) begin
			if (scan_q[i]) pick = CLI_AW'(i);
		end
	end

	assign scan_rest = scan_q & (scan_q - NUM_CLIENTS'(1));

	always_ff @(posedge clk) begin
		if (cmd.reply) begin
			scan_q <= entry_q.waiters;
		end else if (cmd.retry) begin
			scan_q <= scan_rest;
		end
	end

	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.reply || cmd.revoke || cmd.retry) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reply) begin
			out_kind_q   <= KIND_REPLY;
			out_status_q <= reply_status;
			out_target_q <= cli_q;
			out_lock_q   <= lk_q;
			out_last_q   <= !(need_revoke || has_retry);
		end else if (cmd.revoke) begin
			out_kind_q   <= KIND_REVOKE;
			out_status_q <= ST_OK;
			out_target_q <= entry_q.owner;
			out_lock_q   <= lk_q;
			out_last_q   <= 1'b1;
		end else if (cmd.retry) begin
			out_kind_q   <= KIND_RETRY;
			out_status_q <= ST_OK;
			out_target_q <= CLIENT_W'(pick);
			out_lock_q   <= lk_q;
			out_last_q   <= !(|scan_rest);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.msg_kind      = out_kind_q;
	assign rsp.status        = out_status_q;
	assign rsp.target_client = out_target_q;
	assign rsp.msg_lock      = out_lock_q;
	assign rsp.last          = out_last_q;

	always_comb begin
		sts             = '0;
		sts.accepted    = capture;
		sts.out_free    = out_free;
		sts.need_revoke = need_revoke;
		sts.has_retry   = has_retry;
		sts.retry_more  = |scan_rest;
	end

endmodule

### src/lock_table_revoke_retry.sv
// Top level of the lock table with revoke and retry messages.
// Depends on ltrr_pkg, the channel interfaces, ltrr_ctrl and ltrr_datapath.
//
// One request is handled at a time. A request is taken in the idle state and
// its reply is loaded into the message register in the reply state, once
// that register is free; each revoke or retry message adds a step of its own,
// up to NUM_CLIENTS retries on a release with every client waiting. The per-lock
// row is read from a single-port memory at acceptance and written back on the
// reply step; retries are found by scanning the waiter bitmap one client per
// cycle. Back-pressure on the message channel stretches every step. After reset
// all locks are free and the primary flag is set; no clearing pass is needed.
module lock_table_revoke_retry (
	input  logic       clk,
	input  logic       arst_n,
	ltrr_cfg_if.sink   cfg,
	ltrr_req_if.sink   req,
	ltrr_rsp_if.source rsp
);
	import ltrr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ltrr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	ltrr_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

### src/ltrr_checker.sv
// Port-level checks for the lock table, attached to the top level by bind.
// Depends on ltrr_pkg for message kinds and status codes.
module ltrr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [ltrr_pkg::KIND_W-1:0]   rsp_kind,
	input logic [ltrr_pkg::STATUS_W-1:0] rsp_status,
	input logic [ltrr_pkg::CLIENT_W-1:0] rsp_target,
	input logic [ltrr_pkg::LOCK_W-1:0]   rsp_lock,
	input logic                          rsp_last
);
	import ltrr_pkg::*;

	// One request in flight: no request right after one was taken
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous still in progress");

	// A stalled message holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
		&& $stable(rsp_status) && $stable(rsp_target) && $stable(rsp_lock)
		&& $stable(rsp_last))
		else $error("stalled message changed");

	// A message that is not last is followed at once by the next one
	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
		else $error("gap inside a message burst");

	// Revoke and retry always carry ST_OK; a revoke always closes its burst
	a_msg_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind != KIND_REPLY |-> rsp_status == ST_OK
		&& (rsp_kind == KIND_REVOKE || rsp_kind == KIND_RETRY))
		else $error("bad message kind or status");

	a_revoke_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind == KIND_REVOKE |-> rsp_last)
		else $error("revoke not last in burst");

endmodule

bind lock_table_revoke_retry ltrr_checker u_ltrr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_kind   (rsp.msg_kind),
	.rsp_status (rsp.status),
	.rsp_target (rsp.target_client),
	.rsp_lock   (rsp.msg_lock),
	.rsp_last   (rsp.last)
);
